FILE: sv/assert_macros.svh
// Assertion macros shared by the letter frequency statistics design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, during reset too.
`define LFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/lfs_pkg.sv
// Package with types and constants of the letter frequency statistics block.
package lfs_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int COUNT_WIDTH_DEF   = 24;
    localparam int DEN_W             = 40;
    localparam int NUM_W             = 64;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_ZERO_REF = 2'd2;

    localparam logic MODE_REF  = 1'b0;
    localparam logic MODE_TEXT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  symbol;
        logic [31:0] reference_count;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [23:0] letter_total;
        logic [16:0] coincidence_index;
        logic [16:0] roughness;
        logic [31:0] chi_square;
        logic [1:0]  status;
    } t_out;

endpackage

FILE: sv/letter_frequency_statistics.sv
// Top level of the letter frequency statistics block.
//
// Channel   Direction  Handshake           Payload
// in        input      i_in_valid/o_in_stall   lfs_pkg::t_in
// out       output     o_out_valid/i_out_stall lfs_pkg::t_out
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A reference load reads, then writes its reference memory entry; a counted text symbol
// is a read, then write back of the histogram memory entry.
// The final symbol adds a sum pass over the letters, then a pass per letter that uses the
// shared 64-step restoring divider once, or three times with chi-squared, and a result load.
// Reset is synchronous; the histogram and reference tables read as zero until written.
// A waiting result does not block input; a new result waits until the old one transfers.
module letter_frequency_statistics #(
    parameter int ALPHABET_SIZE = lfs_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_WIDTH   = lfs_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  lfs_pkg::t_in                 i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output lfs_pkg::t_out                o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                   i_cfg_data
);
    import lfs_pkg::*;

    localparam int AW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int NW   = COUNT_WIDTH + AW;
    localparam int INV  = 65536 / ALPHABET_SIZE;
    localparam logic [AW-1:0] LAST_IDX = AW'(ALPHABET_SIZE - 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE, S_INC, S_REF, S_SUM_RD, S_SUM_ACC, S_LET_RD, S_LET_WAIT,
        S_DIV_P, S_SQ_P, S_ACC_P, S_DIV_Q, S_SQ_D, S_ACC_D, S_DIV_T, S_NEXT, S_DONE
    } t_state;

    t_state                 r_state;
    logic [7:0]             r_period;
    logic [7:0]             r_offset;
    logic [7:0]             r_skip;
    logic [7:0]             r_phase;
    logic                   r_last;
    logic [AW-1:0]          r_idx;
    logic [31:0]            r_rc;
    logic [DEN_W-1:0]       r_ref_total;
    logic [NW-1:0]          r_n;
    logic                   r_zero_ref;
    logic [1:0]             r_status;
    logic [63:0]            r_ic_acc;
    logic [31:0]            r_chi;
    logic [31:0]            r_ref;
    logic [31:0]            r_p;
    logic [31:0]            r_q;
    logic [31:0]            r_sq_in;
    logic [63:0]            r_sq;
    logic [NUM_W-1:0]       r_num;
    logic [DEN_W-1:0]       r_den;
    logic [DEN_W:0]         r_rem;
    logic [NUM_W-1:0]       r_quo;
    logic [5:0]             r_cnt;
    logic                   r_out_valid;
    t_out                   r_out;

    logic [COUNT_WIDTH-1:0] r_hist_mem [ALPHABET_SIZE];
    logic [31:0]            r_ref_mem  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_hvld;
    logic [ALPHABET_SIZE-1:0] r_rvld;
    logic [COUNT_WIDTH-1:0] r_hist_q;
    logic [31:0]            r_ref_q;
    logic                   r_hvld_q;
    logic                   r_rvld_q;

    logic [AW-1:0]          rd_addr;
    logic                   in_xfer;
    logic                   cfg_xfer;
    logic                   sym_ok;
    logic                   count_hit;
    logic [COUNT_WIDTH-1:0] hval;
    logic [31:0]            rval;
    logic                   hist_we;
    logic                   ref_we;
    logic [COUNT_WIDTH-1:0] hist_wdata;
    logic [DEN_W:0]         n_sh;
    logic                   n_ge;
    logic [DEN_W:0]         n_rem;
    logic [NUM_W-1:0]       n_quo;
    logic [NW-1:0]          n_sum;
    logic [31:0]            n_qv;
    logic [32:0]            n_chi;
    logic [16:0]            ic;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign rd_addr   = (r_state == S_IDLE) ? i_in.symbol[AW-1:0] : r_idx;
    assign sym_ok    = (i_in.symbol < 8'(ALPHABET_SIZE));
    assign count_hit = (r_skip == 8'd0) && (r_phase == 8'd0) && sym_ok;
    assign hval      = r_hvld_q ? r_hist_q : '0;
    assign rval      = r_rvld_q ? r_ref_q : '0;

    assign hist_we    = (r_state == S_INC);
    assign hist_wdata = (hval == CMAX) ? hval : hval + 1'b1;
    assign ref_we     = (r_state == S_REF);

    assign n_sh  = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign n_ge  = (n_sh >= {1'b0, r_den});
    assign n_rem = n_ge ? n_sh - {1'b0, r_den} : n_sh;
    assign n_quo = {r_quo[NUM_W-2:0], n_ge};
    assign n_sum = r_n + NW'(hval);
    assign n_qv  = (n_quo[31:0] == 32'd0) ? 32'd1 : n_quo[31:0];
    assign n_chi = {1'b0, r_chi} + {1'b0, n_quo[31:0]};
    assign ic    = r_ic_acc[62:46];

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[r_idx] <= hist_wdata;
        end
        if (ref_we) begin
            r_ref_mem[r_idx] <= r_rc;
        end
        r_hist_q <= r_hist_mem[rd_addr];
        r_ref_q  <= r_ref_mem[rd_addr];
        r_hvld_q <= r_hvld[rd_addr];
        r_rvld_q <= r_rvld[rd_addr];
        r_sq     <= 64'(r_sq_in) * 64'(r_sq_in);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= '0;
            r_offset    <= '0;
            r_skip      <= '0;
            r_phase     <= '0;
            r_ref_total <= '0;
            r_hvld      <= '0;
            r_rvld      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_idx  <= (i_in.mode == MODE_TEXT && i_in.last && !count_hit)
                                  ? '0 : i_in.symbol[AW-1:0];
                        r_rc   <= i_in.reference_count;
                        r_last <= i_in.last;
                        if (i_in.mode == MODE_REF) begin
                            if (sym_ok) begin
                                r_state <= S_REF;
                            end
                        end else begin
                            if (r_skip != 8'd0) begin
                                r_skip <= r_skip - 8'd1;
                            end else if (r_phase == 8'd0) begin
                                r_phase <= r_period;
                            end else begin
                                r_phase <= r_phase - 8'd1;
                            end
                            if (count_hit) begin
                                r_state <= S_INC;
                            end else if (i_in.last) begin
                                r_state <= S_SUM_RD;
                            end
                        end
                    end
                    r_n        <= '0;
                    r_zero_ref <= 1'b0;
                    r_ic_acc   <= '0;
                    r_chi      <= '0;
                    r_status   <= ST_OK;
                end
                S_INC: begin
                    r_hvld[r_idx] <= 1'b1;
                    if (r_last) begin
                        r_state <= S_SUM_RD;
                        r_idx   <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_REF: begin
                    r_rvld[r_idx] <= 1'b1;
                    r_ref_total   <= r_ref_total - DEN_W'(rval) + DEN_W'(r_rc);
                    r_state       <= S_IDLE;
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    r_n <= n_sum;
                    if (rval == 32'd0) begin
                        r_zero_ref <= 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_idx <= '0;
                        if (n_sum == '0) begin
                            r_status <= ST_EMPTY;
                            r_state  <= S_DONE;
                        end else begin
                            if (r_zero_ref || rval == 32'd0 || r_ref_total == '0) begin
                                r_status <= ST_ZERO_REF;
                            end
                            r_state <= S_LET_RD;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SUM_RD;
                    end
                end
                S_LET_RD: begin
                    r_state <= S_LET_WAIT;
                end
                S_LET_WAIT: begin
                    r_ref   <= rval;
                    r_num   <= NUM_W'(hval) << 31;
                    r_den   <= DEN_W'(r_n);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV_P;
                end
                S_DIV_P, S_DIV_Q, S_DIV_T: begin
                    r_rem <= n_rem;
                    r_num <= r_num << 1;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        if (r_state == S_DIV_P) begin
                            r_p     <= n_quo[31:0];
                            r_sq_in <= n_quo[31:0];
                            r_state <= S_SQ_P;
                        end else if (r_state == S_DIV_Q) begin
                            r_q     <= n_qv;
                            r_sq_in <= (r_p > n_qv) ? r_p - n_qv : n_qv - r_p;
                            r_state <= S_SQ_D;
                        end else begin
                            if (n_quo[63:32] != 32'd0 || n_chi[32]) begin
                                r_chi <= 32'hFFFF_FFFF;
                            end else begin
                                r_chi <= n_chi[31:0];
                            end
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_SQ_P: begin
                    r_state <= S_ACC_P;
                end
                S_ACC_P: begin
                    r_ic_acc <= r_ic_acc + r_sq;
                    if (r_status == ST_OK) begin
                        r_num   <= NUM_W'(r_ref) << 31;
                        r_den   <= r_ref_total;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV_Q;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_SQ_D: begin
                    r_state <= S_ACC_D;
                end
                S_ACC_D: begin
                    r_num   <= r_sq >> 15;
                    r_den   <= DEN_W'(r_q);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV_T;
                end
                S_NEXT: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_LET_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid             <= 1'b1;
                        r_out.letter_total      <= (64'(r_n) > 64'hFF_FFFF) ? 24'hFF_FFFF
                                                                            : 24'(r_n);
                        r_out.coincidence_index <= ic;
                        r_out.roughness         <= (ic > 17'(INV)) ? ic - 17'(INV) : 17'd0;
                        r_out.status            <= r_status;
                        if (r_status == ST_EMPTY) begin
                            r_out.chi_square <= 32'd0;
                        end else if (r_status == ST_ZERO_REF) begin
                            r_out.chi_square <= 32'hFFFF_FFFF;
                        end else begin
                            r_out.chi_square <= r_chi;
                        end
                        r_hvld  <= '0;
                        r_skip  <= r_offset;
                        r_phase <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (cfg_xfer) begin
                if (i_cfg_index == REG_PERIOD_STEP) begin
                    r_period <= i_cfg_data;
                    r_skip   <= r_offset;
                    r_phase  <= '0;
                end else if (i_cfg_index == REG_START_OFFSET) begin
                    r_offset <= i_cfg_data;
                    r_skip   <= i_cfg_data;
                    r_phase  <= '0;
                end
            end
        end
    end

`include "assert_macros.svh"

    `LFS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "block not idle after reset")
    `LFS_ASSERT(a_div_rem, i_clk, i_rst_n, (r_state == S_DIV_P || r_state == S_DIV_Q || r_state == S_DIV_T) |-> (r_rem < {1'b0, r_den}), "divider remainder not below divisor")
    `LFS_ASSERT(a_load_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result loaded outside the final state")
    `LFS_ASSERT(a_empty_total, i_clk, i_rst_n, (r_out_valid && r_out.status == ST_EMPTY) |-> (r_out.letter_total == 24'd0), "empty status with nonzero total")

endmodule
